// ===== rtl/gora_pkg.sv =====
// shared types, constants and the reciprocal table of the gyro averaging block
package gora_pkg;

  // kept counts hold 0..16 samples
  localparam int KCNT_W = 5;
  // reciprocal scale: floor(2^RCP_SH / d)
  localparam int RCP_SH = 20;
  localparam int RCP_W  = 21;
  localparam int SMP_W  = 16;
  localparam int LIM_W  = 15;
  localparam logic [LIM_W-1:0] LIMIT_RST = 15'd470;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_OFFSET_X     = 2'd0;
  localparam cfg_idx_t REG_OFFSET_Y     = 2'd1;
  localparam cfg_idx_t REG_OFFSET_Z     = 2'd2;
  localparam cfg_idx_t REG_REJECT_LIMIT = 2'd3;

  typedef struct packed {
    logic [SMP_W-1:0] raw_x;
    logic [SMP_W-1:0] raw_y;
    logic [SMP_W-1:0] raw_z;
  } in_t;

  typedef struct packed {
    logic signed [SMP_W-1:0] mean_x;
    logic signed [SMP_W-1:0] mean_y;
    logic signed [SMP_W-1:0] mean_z;
    logic signed [SMP_W-1:0] ref_x;
    logic signed [SMP_W-1:0] ref_y;
    logic signed [SMP_W-1:0] ref_z;
    logic                    all_valid;
  } out_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic take;     // store an accepted sample
    logic clr_acc;  // clear the axis accumulators
    logic rd_en;    // read one stored entry
    logic div_en;   // reciprocal multiply
    logic acc_en;   // correct quotient and accumulate
    logic finish;   // load the result register
  } dp_cmd_t;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_READ = 5'b00010,
    ST_DIV  = 5'b00100,
    ST_ACC  = 5'b01000,
    ST_OUT  = 5'b10000
  } state_t;

  // floor(2^20 / d) for d = 1..16, zero for an empty axis
  function automatic logic [RCP_W-1:0] recip(input logic [KCNT_W-1:0] d);
    logic [RCP_W-1:0] r;
    case (d)
      5'd1:    r = 21'd1048576;
      5'd2:    r = 21'd524288;
      5'd3:    r = 21'd349525;
      5'd4:    r = 21'd262144;
      5'd5:    r = 21'd209715;
      5'd6:    r = 21'd174762;
      5'd7:    r = 21'd149796;
      5'd8:    r = 21'd131072;
      5'd9:    r = 21'd116508;
      5'd10:   r = 21'd104857;
      5'd11:   r = 21'd95325;
      5'd12:   r = 21'd87381;
      5'd13:   r = 21'd80659;
      5'd14:   r = 21'd74898;
      5'd15:   r = 21'd69905;
      5'd16:   r = 21'd65536;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/gora_ctrl.sv =====
// controller: sample intake, per-entry divide sequence and result handshake
module gora_ctrl #(
  parameter int WINDOW = 10,
  localparam int AW = (WINDOW > 1) ? $clog2(WINDOW) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output gora_pkg::dp_cmd_t cmd,
  output logic [AW-1:0]     addr
);

  localparam logic [AW-1:0] LAST = AW'(WINDOW - 1);

  gora_pkg::state_t state_r, state_nxt;
  logic [AW-1:0]    fill_r, fill_nxt;
  logic [AW-1:0]    idx_r, idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             accept;

  assign in_stall  = (state_r != gora_pkg::ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign addr      = (state_r == gora_pkg::ST_IDLE) ? fill_r : idx_r;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    idx_nxt   = idx_r;
    cmd       = '0;
    unique case (state_r)
      gora_pkg::ST_IDLE: begin
        if (accept) begin
          cmd.take = 1'b1;
          if (fill_r == LAST) begin
            fill_nxt    = '0;
            idx_nxt     = '0;
            cmd.clr_acc = 1'b1;
            state_nxt   = gora_pkg::ST_READ;
          end else begin
            fill_nxt = fill_r + AW'(1);
          end
        end
      end
      gora_pkg::ST_READ: begin
        cmd.rd_en = 1'b1;
        state_nxt = gora_pkg::ST_DIV;
      end
      gora_pkg::ST_DIV: begin
        cmd.div_en = 1'b1;
        state_nxt  = gora_pkg::ST_ACC;
      end
      gora_pkg::ST_ACC: begin
        cmd.acc_en = 1'b1;
        if (idx_r == LAST) begin
          state_nxt = gora_pkg::ST_OUT;
        end else begin
          idx_nxt   = idx_r + AW'(1);
          state_nxt = gora_pkg::ST_READ;
        end
      end
      gora_pkg::ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.finish = 1'b1;
          state_nxt  = gora_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = gora_pkg::ST_IDLE;
      end
    endcase
  end

  // result register occupancy
  always_comb begin
    priority if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gora_pkg::ST_IDLE;
      fill_r      <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // a new result never overwrites one that is still pending
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (!out_valid_r || !out_stall))
    else $error("result loaded over a pending transaction");

  // a loaded result is offered in the next cycle
  a_finish_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_valid)
    else $error("result not offered after load");

  // fill and entry indexes stay inside the window
  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r <= LAST) && (idx_r <= LAST))
    else $error("window index out of range");

  // the window wraps only into the divide sequence
  a_wrap_read: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.take && fill_r == LAST) |=> (state_r == gora_pkg::ST_READ))
    else $error("full window did not start the divide sequence");

endmodule

// ===== rtl/gora_dp.sv =====
// datapath: offset and rejection, sample store, reciprocal divide and sums
module gora_dp #(
  parameter int WINDOW = 10,
  localparam int AW = (WINDOW > 1) ? $clog2(WINDOW) : 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  gora_pkg::cfg_idx_t         cfg_index,
  input  logic [gora_pkg::SMP_W-1:0] cfg_data,
  input  gora_pkg::in_t              in_data,
  input  gora_pkg::dp_cmd_t          cmd,
  input  logic [AW-1:0]              addr,
  output gora_pkg::out_t             out_data
);

  localparam int SW = gora_pkg::SMP_W;
  localparam int KW = gora_pkg::KCNT_W;
  localparam int PW = SW + gora_pkg::RCP_W;
  localparam logic [KW-1:0] KEPT_RST = KW'(WINDOW);

  logic [SW-1:0]                offset_r [3];
  logic [gora_pkg::LIM_W-1:0]   limit_r;
  logic [KW-1:0]                kept_r [3];
  logic [3*SW-1:0]              mem [WINDOW];
  logic [3*SW-1:0]              rd_r;
  logic [SW-1:0]                q0_r [3];
  logic [SW-1:0]                mag_r [3];
  logic                         neg_r [3];
  logic [SW-1:0]                acc_r [3];
  logic [SW-1:0]                ref_r [3];
  logic                         ref_taken_r;
  gora_pkg::out_t               out_r;

  logic [SW-1:0]   raw [3];
  logic [SW-1:0]   diff [3];
  logic            rej [3];
  logic [SW-1:0]   kept_smp [3];
  logic [SW-1:0]   smp [3];
  logic [SW-1:0]   mag [3];
  logic [PW-1:0]   prod [3];
  logic [SW+KW-1:0] qd [3];
  logic [SW+KW-1:0] rem [3];
  logic [SW-1:0]   q [3];
  logic [SW-1:0]   mean [3];
  logic            valid;

  assign raw[0] = in_data.raw_x;
  assign raw[1] = in_data.raw_y;
  assign raw[2] = in_data.raw_z;

  // offset subtraction and outlier test per axis
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      diff[k]     = raw[k] - offset_r[k];
      rej[k]      = ($signed({diff[k][SW-1], diff[k]}) > $signed({2'b00, limit_r})) ||
                    ($signed({diff[k][SW-1], diff[k]}) < -$signed({2'b00, limit_r}));
      kept_smp[k] = rej[k] ? '0 : diff[k];
    end
  end

  // divide stages: reciprocal multiply, then remainder correction
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      smp[k]  = rd_r[k*SW +: SW];
      mag[k]  = smp[k][SW-1] ? SW'(~smp[k] + 1'b1) : smp[k];
      prod[k] = PW'(mag[k]) * PW'(gora_pkg::recip(kept_r[k]));
      qd[k]   = (SW+KW)'(q0_r[k]) * (SW+KW)'(kept_r[k]);
      rem[k]  = (SW+KW)'(mag_r[k]) - qd[k];
      q[k]    = q0_r[k] + SW'(rem[k] >= (SW+KW)'(kept_r[k]));
    end
  end

  // window verdict and final means
  assign valid = (kept_r[0] != '0) && (kept_r[1] != '0) && (kept_r[2] != '0);
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mean[k] = valid ? acc_r[k] : '0;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r[0] <= '0;
      offset_r[1] <= '0;
      offset_r[2] <= '0;
      limit_r     <= gora_pkg::LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gora_pkg::REG_OFFSET_X:     offset_r[0] <= cfg_data;
        gora_pkg::REG_OFFSET_Y:     offset_r[1] <= cfg_data;
        gora_pkg::REG_OFFSET_Z:     offset_r[2] <= cfg_data;
        gora_pkg::REG_REJECT_LIMIT: limit_r     <= cfg_data[gora_pkg::LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // kept counts per axis
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 3; k++) kept_r[k] <= KEPT_RST;
    end else begin
      for (int k = 0; k < 3; k++) begin
        if (cmd.finish) begin
          kept_r[k] <= KEPT_RST;
        end else if (cmd.take && rej[k] && kept_r[k] != '0) begin
          kept_r[k] <= kept_r[k] - KW'(1);
        end
      end
    end
  end

  // sample store, one write or one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      mem[addr] <= {kept_smp[2], kept_smp[1], kept_smp[0]};
    end
    if (cmd.rd_en) begin
      rd_r <= mem[addr];
    end
  end

  // quotient estimate and accumulation
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      if (cmd.div_en) begin
        q0_r[k]  <= prod[k][gora_pkg::RCP_SH +: SW];
        mag_r[k] <= mag[k];
        neg_r[k] <= smp[k][SW-1];
      end
      if (cmd.clr_acc) begin
        acc_r[k] <= '0;
      end else if (cmd.acc_en) begin
        acc_r[k] <= neg_r[k] ? (acc_r[k] - q[k]) : (acc_r[k] + q[k]);
      end
    end
  end

  // reference latch
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_taken_r <= 1'b0;
      for (int k = 0; k < 3; k++) ref_r[k] <= '0;
    end else if (cmd.finish && !ref_taken_r) begin
      ref_taken_r <= 1'b1;
      for (int k = 0; k < 3; k++) ref_r[k] <= mean[k];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_r.mean_x    <= mean[0];
      out_r.mean_y    <= mean[1];
      out_r.mean_z    <= mean[2];
      out_r.ref_x     <= ref_taken_r ? ref_r[0] : mean[0];
      out_r.ref_y     <= ref_taken_r ? ref_r[1] : mean[1];
      out_r.ref_z     <= ref_taken_r ? ref_r[2] : mean[2];
      out_r.all_valid <= valid;
    end
  end

  assign out_data = out_r;

endmodule

// ===== rtl/gyro_outlier_rejecting_average_core.sv =====
// top level of the outlier-rejecting gyro window average
// Usage:
//   in_*   : one transaction per sample triple (raw_x, raw_y, raw_z), taken when
//            in_valid is high and in_stall is low.
//   out_*  : one transaction per completed window of WINDOW samples, carrying the
//            three means, the reference means and all_valid.
//   cfg_*  : register writes (offsets, reject limit), always ready; write only
//            while the block is idle.
// Window sequence:
//   within a window a sample is taken every cycle. The last sample of a window
//   starts a divide sequence that takes each stored entry through the store read,
//   the reciprocal multiply, and the remainder correction and sum; in_stall stays
//   high until the result is loaded, so no new sample is taken in the meantime.
//   The divide sequence over the single-port sample store limits the window rate.
// Reset: synchronous rst_n resets the controller, kept counts (to WINDOW), reference and
//   registers (limit 470, offsets 0); the sample store needs no clearing.
// Stall: a result waits in the output register while out_stall is high; sampling
//   continues, and the next result waits until the register is free.
module gyro_outlier_rejecting_average_core #(
  parameter int WINDOW = 10
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  gora_pkg::in_t              in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output gora_pkg::out_t             out_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  gora_pkg::cfg_idx_t         cfg_index,
  input  logic [gora_pkg::SMP_W-1:0] cfg_data
);

  localparam int AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  gora_pkg::dp_cmd_t cmd;
  logic [AW-1:0]     addr;

  assign cfg_ready = 1'b1;

  gora_ctrl #(
    .WINDOW(WINDOW)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .cmd      (cmd),
    .addr     (addr)
  );

  gora_dp #(
    .WINDOW(WINDOW)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_data  (in_data),
    .cmd      (cmd),
    .addr     (addr),
    .out_data (out_data)
  );

endmodule

// ===== verif/gyro_outlier_rejecting_average_core_test.sv =====
// self-checking testbench of the outlier-rejecting gyro window average core
module gyro_outlier_rejecting_average_core_test;

  localparam int WINDOW     = 10;
  // cycles the block may still be busy after its last result
  localparam int SETTLE     = 4 * WINDOW + 10;
  localparam int LONG_HOLD  = 500;
  localparam int PHASE_LEN  = 135;
  localparam int RUN_LIMIT  = 600000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  gora_pkg::in_t      in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  gora_pkg::out_t     out_data;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  gora_pkg::cfg_idx_t cfg_index = gora_pkg::REG_OFFSET_X;
  logic [15:0]        cfg_data = '0;

  gyro_outlier_rejecting_average_core #(.WINDOW(WINDOW)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // pending samples, expected window results and bookkeeping
  gora_pkg::in_t  pending_samples[$];
  gora_pkg::out_t expected_means[$];
  int   pushed_cnt = 0;
  int   accepted_cnt = 0;
  int   mismatches = 0;

  // idling knobs, changed between phases
  int   stall_pct = 30;
  int   gap_max = 3;
  int   max_burst = 6;
  int   hold_asked = 0;
  int   hold_taken = 0;
  int   hold_left = 0;
  int   gap_left = 0;
  int   burst_left = 1;

  // window average state mirrored in the testbench
  logic [15:0] axis_offset[3] = '{16'd0, 16'd0, 16'd0};
  int          reject_lim = 470;
  int          win_samples[WINDOW][3];
  int          fill_cnt = 0;
  int          kept_cnt[3] = '{WINDOW, WINDOW, WINDOW};
  int          ref_mean[3] = '{0, 0, 0};
  bit          ref_taken = 1'b0;

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    repeat (RUN_LIMIT) @(posedge clk);
    $display("gyro_outlier_rejecting_average_core_test failed");
    $finish;
  end

  // take one sample triple and, at the window end, produce the expected means
  task automatic predict_window_mean(input gora_pkg::in_t smp);
    logic [15:0]    raw[3];
    logic [15:0]    diff;
    int             s;
    int             acc;
    int             mean[3];
    bit             valid;
    gora_pkg::out_t e;
    raw = '{smp.raw_x, smp.raw_y, smp.raw_z};
    if (fill_cnt >= WINDOW) fill_cnt = 0;
    for (int k = 0; k < 3; k++) begin
      diff = raw[k] - axis_offset[k];
      s = $signed(diff);
      if (s > reject_lim || s < -reject_lim) begin
        s = 0;
        if (kept_cnt[k] > 0) kept_cnt[k]--;
      end
      win_samples[fill_cnt][k] = s;
    end
    fill_cnt++;
    if (fill_cnt == WINDOW) begin
      valid = kept_cnt[0] != 0 && kept_cnt[1] != 0 && kept_cnt[2] != 0;
      for (int k = 0; k < 3; k++) begin
        acc = 0;
        // signed division truncates toward zero
        if (valid)
          for (int i = 0; i < WINDOW; i++) acc += win_samples[i][k] / kept_cnt[k];
        mean[k] = acc;
      end
      if (!ref_taken) begin
        ref_mean = mean;
        ref_taken = 1'b1;
      end
      e.mean_x = mean[0][15:0];
      e.mean_y = mean[1][15:0];
      e.mean_z = mean[2][15:0];
      e.ref_x = ref_mean[0][15:0];
      e.ref_y = ref_mean[1][15:0];
      e.ref_z = ref_mean[2][15:0];
      e.all_valid = valid;
      expected_means.push_back(e);
      kept_cnt = '{WINDOW, WINDOW, WINDOW};
      fill_cnt = 0;
    end
  endtask

  function automatic void check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  function automatic gora_pkg::in_t mk(input int x, input int y, input int z);
    gora_pkg::in_t s;
    s.raw_x = x[15:0];
    s.raw_y = y[15:0];
    s.raw_z = z[15:0];
    return s;
  endfunction

  // one axis word around the offset: mostly in range, some outliers and edges
  function automatic logic [15:0] gen_axis(input logic [15:0] off, input int lim,
                                          input bit outlier);
    int r;
    int delta;
    r = $urandom_range(99);
    if (!outlier && r < 8) return 16'($urandom);
    if (outlier || r < 18) begin
      if (lim >= 32767) delta = -32768;
      else begin
        delta = $urandom_range(32767, lim + 1);
        if ($urandom_range(1)) delta = -delta;
        if (delta == -32767 && $urandom_range(1)) delta = -32768;
      end
    end else if (r < 26) delta = $urandom_range(1) ? lim : -lim;
    else if (r < 30) delta = 0;
    else delta = int'($urandom_range(2 * lim)) - lim;
    return off + delta[15:0];
  endfunction

  function automatic void push_sample(input gora_pkg::in_t s);
    pending_samples.push_back(s);
    pushed_cnt++;
  endfunction

  task automatic write_reg(input gora_pkg::cfg_idx_t idx, input logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // wait for all samples taken and all results seen, then let the block settle
  task automatic drain();
    while (accepted_cnt != pushed_cnt) @(posedge clk);
    while (expected_means.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // queue a phase of random samples; now and then one axis rejects a whole window
  task automatic queue_random(input int n);
    int            bad_axis;
    gora_pkg::in_t s;
    bad_axis = 3;
    for (int j = 0; j < n; j++) begin
      if (pushed_cnt % WINDOW == 0)
        bad_axis = ($urandom_range(99) < 15) ? $urandom_range(2) : 3;
      s.raw_x = gen_axis(axis_offset[0], reject_lim, bad_axis == 0);
      s.raw_y = gen_axis(axis_offset[1], reject_lim, bad_axis == 1);
      s.raw_z = gen_axis(axis_offset[2], reject_lim, bad_axis == 2);
      push_sample(s);
    end
  endtask

  // input driver: bursts of random length separated by random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_samples.size() > 0) begin
        in_data <= pending_samples.pop_front();
        in_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(max_burst, 1);
          gap_left <= $urandom_range(gap_max);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // accepted sample transactions feed the prediction
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      predict_window_mean(in_data);
      accepted_cnt++;
    end
  end

  // register writes update the mirrored configuration
  always @(posedge clk) begin
    if (rst_n && cfg_valid && cfg_ready) begin
      case (cfg_index)
        gora_pkg::REG_OFFSET_X: axis_offset[0] = cfg_data;
        gora_pkg::REG_OFFSET_Y: axis_offset[1] = cfg_data;
        gora_pkg::REG_OFFSET_Z: axis_offset[2] = cfg_data;
        gora_pkg::REG_REJECT_LIMIT: reject_lim = int'(cfg_data[14:0]);
        default: ;
      endcase
    end
  end

  // result receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (hold_taken != hold_asked) begin
      hold_taken <= hold_asked;
      hold_left <= LONG_HOLD;
      out_stall <= 1'b1;
    end else begin
      out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end
  end

  // result monitor
  always @(posedge clk) begin : result_monitor
    gora_pkg::out_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_means.size() == 0) begin
        $error("result transaction with no expected result pending");
        mismatches++;
      end else begin
        e = expected_means.pop_front();
        check_field("mean_x", e.mean_x, out_data.mean_x);
        check_field("mean_y", e.mean_y, out_data.mean_y);
        check_field("mean_z", e.mean_z, out_data.mean_z);
        check_field("ref_x", e.ref_x, out_data.ref_x);
        check_field("ref_y", e.ref_y, out_data.ref_y);
        check_field("ref_z", e.ref_z, out_data.ref_z);
        check_field("all_valid", e.all_valid, out_data.all_valid);
      end
    end
  end

  initial begin
    int offs[3];
    int lim;
    while (!rst_n) @(posedge clk);
    @(posedge clk);

    // first window: x rejects every sample, so the zero means become the reference
    push_sample(mk(32767, 0, 0));
    push_sample(mk(-32768, -1, 470));
    push_sample(mk(471, -470, -471));
    push_sample(mk(-471, 471, -1));
    push_sample(mk(1000, 32767, 1));
    push_sample(mk(-4096, -32768, -1));
    for (int i = 6; i < 10; i++) push_sample(mk(500 + i * 1000, i * 37, -i * 41));
    // second window: x keeps all, y drops one, z keeps a single sample
    for (int i = 10; i < 20; i++)
      push_sample(mk(i * 83 - 1200, (i == 13) ? 16384 : 200 - i * 23,
                     (i == 17) ? 333 : 20000));
    // a partial window left open across the next register writes
    for (int i = 20; i < 25; i++) push_sample(mk(i * 11 - 250, -(i * 7), i * 3));
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      offs = '{$urandom_range(65535), $urandom_range(65535), $urandom_range(65535)};
      case (ph)
        0: begin offs = '{-32768, 32767, 0}; lim = 32767; end
        1: begin offs = '{0, 0, 0}; lim = 0; end
        2: begin offs = '{32767, -32768, 1}; lim = 5; end
        3: lim = 470;
        4: lim = $urandom_range(2000, 1);
        5: lim = $urandom_range(32767);
        6: begin offs = '{0, 0, 0}; lim = 470; end
        default: lim = 100;
      endcase
      write_reg(gora_pkg::REG_OFFSET_X, offs[0][15:0]);
      write_reg(gora_pkg::REG_OFFSET_Y, offs[1][15:0]);
      write_reg(gora_pkg::REG_OFFSET_Z, offs[2][15:0]);
      write_reg(gora_pkg::REG_REJECT_LIMIT, lim[15:0]);
      @(posedge clk);

      // phase 6 runs without idling, phase 7 keeps offering through a long hold-off
      stall_pct = (ph == 6) ? 0 : ((ph % 2) ? 60 : 25);
      gap_max = (ph >= 6) ? 0 : (ph % 3) * 4 + 1;
      max_burst = 1 + ph * 3;
      if (ph == 7) hold_asked++;
      queue_random(PHASE_LEN);
      drain();
    end

    if (mismatches == 0 && expected_means.size() == 0) begin
      $display("gyro_outlier_rejecting_average_core_test passed");
    end else begin
      $display("gyro_outlier_rejecting_average_core_test failed");
    end
    $finish;
  end

endmodule
